/* hw/rtl/wbps_pkg.sv */
`default_nettype none
package wbps_pkg;

    // Defaults for the top-level parameters
    localparam int PATTERN_MAX_DEF = 16;
    localparam int OFFSET_BITS_DEF = 32;
    localparam int COUNT_BITS_DEF  = 16;
    localparam int QUEUE_DEPTH_DEF = 4;

    // Fixed field widths
    localparam int PAT_BYTES    = 16;   // bytes held by the two pattern registers
    localparam int CARE_W       = 16;
    localparam int LEN_W        = 5;
    localparam int BYTE_W       = 8;
    localparam int COUNT_OUT_W  = 16;
    localparam int OFFSET_OUT_W = 32;
    localparam int CFG_IDX_W    = 8;
    localparam int CFG_DATA_W   = 64;
    // Holds window position + pattern byte index + 1 for any window up to 64 bytes
    localparam int SEL_W        = 7;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_LOW  = 8'd0,
        REG_PATTERN_HIGH = 8'd1,
        REG_CARE_MASK    = 8'd2,
        REG_PATTERN_LEN  = 8'd3
    } t_cfg_reg;

    typedef struct packed {
        logic [PAT_BYTES*BYTE_W-1:0] pattern;
        logic [CARE_W-1:0]           care;
        logic [LEN_W-1:0]            len;
    } t_cfg;

    // Front-to-queue handshake
    typedef struct packed {
        logic push;
        logic full;
    } t_q_wr;

endpackage
`default_nettype wire

/* hw/rtl/wbps_ifs.sv */
`default_nettype none
interface wbps_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] region_byte;
    logic       last_byte;

    modport source (output valid, output region_byte, output last_byte, input ready);
    modport sink   (input valid, input region_byte, input last_byte, output ready);
endinterface

interface wbps_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] match_count;
    logic [31:0] match_offset;
    logic        unique_match;

    modport source (output valid, output match_count, output match_offset,
                    output unique_match, input ready);
    modport sink   (input valid, input match_count, input match_offset,
                    input unique_match, output ready);
endinterface

interface wbps_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [63:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

/* hw/rtl/wbps_front.sv */
`default_nettype none
module wbps_front #(
    parameter int PATTERN_MAX = wbps_pkg::PATTERN_MAX_DEF,
    parameter int OFFSET_BITS = wbps_pkg::OFFSET_BITS_DEF
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire wbps_pkg::t_cfg   i_cfg,
    wbps_in_if.sink               i_in,
    output wbps_pkg::t_q_wr       o_q_wr,
    input  wire                   i_q_full,
    output logic [OFFSET_BITS+1:0] o_rec
);
    import wbps_pkg::*;

    logic [BYTE_W-1:0]      r_win [PATTERN_MAX];
    logic [BYTE_W-1:0]      w_win [PATTERN_MAX];
    logic [OFFSET_BITS-1:0] r_seen;
    logic [OFFSET_BITS-1:0] n_seen;
    logic [OFFSET_BITS-1:0] w_start;
    logic [PATTERN_MAX-1:0] w_miss;
    logic                   w_len_ok;
    logic                   w_hit;
    logic                   w_acc;

    assign i_in.ready = ~i_q_full;
    assign w_acc      = i_in.valid & ~i_q_full;

    // Window as it stands after the incoming byte shifts in
    always_comb begin
        w_win[0] = i_in.region_byte;
        for (int j = 1; j < PATTERN_MAX; j++) w_win[j] = r_win[j-1];
    end

    // Window position j holds pattern byte len-1-j; bytes past sixteen are wildcards
    always_comb begin
        logic [BYTE_W-1:0] want;
        logic              care;
        for (int j = 0; j < PATTERN_MAX; j++) begin
            want = '0;
            care = 1'b0;
            for (int i = 0; i < PAT_BYTES; i++) begin
                if (SEL_W'(j) + SEL_W'(i) + SEL_W'(1) == SEL_W'(i_cfg.len)) begin
                    want = i_cfg.pattern[i*BYTE_W +: BYTE_W];
                    care = i_cfg.care[i];
                end
            end
            w_miss[j] = care && (w_win[j] != want);
        end
    end

    assign n_seen   = (r_seen == '1) ? r_seen : r_seen + OFFSET_BITS'(1);
    assign w_len_ok = (i_cfg.len != '0) && (SEL_W'(i_cfg.len) <= SEL_W'(PATTERN_MAX));
    assign w_hit    = w_len_ok && (n_seen >= OFFSET_BITS'(i_cfg.len)) && ~|w_miss;
    assign w_start  = n_seen - OFFSET_BITS'(i_cfg.len);

    assign o_q_wr.push = w_acc;
    assign o_q_wr.full = i_q_full;
    assign o_rec       = {w_hit, i_in.last_byte, w_start};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
        end else if (w_acc) begin
            r_seen <= i_in.last_byte ? '0 : n_seen;
        end
    end

    // Window payload needs no clear: the byte count gates every compare
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            for (int j = 0; j < PATTERN_MAX; j++) r_win[j] <= w_win[j];
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/wbps_queue.sv */
`default_nettype none
module wbps_queue #(
    parameter int WIDTH = 34,
    parameter int DEPTH = wbps_pkg::QUEUE_DEPTH_DEF
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire wbps_pkg::t_q_wr i_wr,
    input  wire [WIDTH-1:0]      i_data,
    output logic                 o_full,
    output logic                 o_valid,
    input  wire                  i_pop,
    output logic [WIDTH-1:0]     o_data
);
    import wbps_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             w_push, w_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign w_push  = i_wr.push & ~i_wr.full;
    assign w_pop   = i_pop & o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            if (w_pop)  r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            unique case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + CNT_W'(1);
                2'b01:   r_cnt <= r_cnt - CNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wr] <= i_data;
    end

endmodule
`default_nettype wire

/* hw/rtl/wbps_back.sv */
`default_nettype none
module wbps_back #(
    parameter int OFFSET_BITS = wbps_pkg::OFFSET_BITS_DEF,
    parameter int COUNT_BITS  = wbps_pkg::COUNT_BITS_DEF
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_q_valid,
    input  wire [OFFSET_BITS+1:0]  i_rec,
    output logic                   o_pop,
    wbps_out_if.source             o_out
);
    import wbps_pkg::*;

    logic                          w_hit, w_last;
    logic [OFFSET_BITS-1:0]        w_start;
    logic [COUNT_BITS-1:0]         r_count, n_count;
    logic [OFFSET_BITS-1:0]        r_first, n_first;
    logic [COUNT_BITS+COUNT_OUT_W-1:0]   w_cnt_ext;
    logic [OFFSET_BITS+OFFSET_OUT_W-1:0] w_off_ext;
    logic                          w_uniq;
    logic                          r_out_valid;
    logic [COUNT_OUT_W-1:0]        r_out_count;
    logic [OFFSET_OUT_W-1:0]       r_out_offset;
    logic                          r_out_unique;

    assign {w_hit, w_last, w_start} = i_rec;

    // Non-final items always drain; the final one waits for a free output slot
    assign o_pop = i_q_valid && (!w_last || !r_out_valid || o_out.ready);

    assign n_count   = (w_hit && r_count != '1) ? r_count + COUNT_BITS'(1) : r_count;
    assign n_first   = (w_hit && r_count == '0) ? w_start : r_first;
    assign w_uniq    = (n_count == COUNT_BITS'(1));
    assign w_cnt_ext = {{COUNT_OUT_W{1'b0}}, n_count};
    assign w_off_ext = {{OFFSET_OUT_W{1'b0}}, n_first};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_first     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_count <= w_last ? '0 : n_count;
                r_first <= w_last ? '0 : n_first;
            end
            priority if (o_pop && w_last) r_out_valid <= 1'b1;
            else if (o_out.ready)        r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && w_last) begin
            r_out_count  <= w_cnt_ext[COUNT_OUT_W-1:0];
            r_out_offset <= w_uniq ? w_off_ext[OFFSET_OUT_W-1:0] : '0;
            r_out_unique <= w_uniq;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.match_count  = r_out_count;
    assign o_out.match_offset = r_out_offset;
    assign o_out.unique_match = r_out_unique;

endmodule
`default_nettype wire

/* hw/rtl/wildcard_byte_pattern_scanner_core.sv */
`default_nettype none
// Wildcard byte pattern scanner. Stream a region in one byte per item on i_in,
// marking its final byte with last_byte; one result item follows on o_out with
// the number of start positions (overlaps included) where the pattern matches,
// saturating at 2^COUNT_BITS-1, and, when exactly one match was found, its start
// offset from zero and the unique_match flag (both zero otherwise). Pattern bytes
// with a clear care bit are wildcards; a pattern length of zero or above
// PATTERN_MAX never matches. Write the four registers on i_cfg (index 0 pattern
// bytes 0-7, 1 bytes 8-15, 2 care mask, 3 length) only while no region is in
// flight; other indexes are ignored, and the config channel is always ready.
// Rate: one byte per cycle sustained. The front end compares the shifted window
// against the pattern in the cycle a byte is accepted and pushes a small record
// into a 4-entry queue; the back end folds one record per cycle into the running
// count. o_out.valid rises once the final byte's record has left the queue and been
// folded into the result, which is held in an output register so the next region
// can stream in while it waits. A result that waits holds back only the next final
// byte, until the queue fills and stalls i_in.
module wildcard_byte_pattern_scanner_core #(
    parameter int PATTERN_MAX = wbps_pkg::PATTERN_MAX_DEF,
    parameter int OFFSET_BITS = wbps_pkg::OFFSET_BITS_DEF,
    parameter int COUNT_BITS  = wbps_pkg::COUNT_BITS_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    wbps_cfg_if.sink    i_cfg,
    wbps_in_if.sink     i_in,
    wbps_out_if.source  o_out
);
    import wbps_pkg::*;

    localparam int REC_W = OFFSET_BITS + 2;

    logic [CFG_DATA_W-1:0] r_pat_lo, r_pat_hi;
    logic [CARE_W-1:0]     r_care;
    logic [LEN_W-1:0]      r_len;
    t_cfg                  w_cfg;
    t_q_wr                 w_q_wr;
    logic                  w_q_full, w_q_valid, w_pop;
    logic [REC_W-1:0]      w_rec_in, w_rec_out;

    // Config registers: accept every write, drop unknown indexes
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_lo <= '0;
            r_pat_hi <= '0;
            r_care   <= '0;
            r_len    <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_PATTERN_LOW:  r_pat_lo <= i_cfg.data;
                REG_PATTERN_HIGH: r_pat_hi <= i_cfg.data;
                REG_CARE_MASK:    r_care   <= i_cfg.data[CARE_W-1:0];
                REG_PATTERN_LEN:  r_len    <= i_cfg.data[LEN_W-1:0];
                default:          ;
            endcase
        end
    end

    assign w_cfg.pattern = {r_pat_hi, r_pat_lo};
    assign w_cfg.care    = r_care;
    assign w_cfg.len     = r_len;

    // Front end: shift window, compare, tag each byte as hit or miss
    wbps_front #(
        .PATTERN_MAX (PATTERN_MAX),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (w_cfg),
        .i_in     (i_in),
        .o_q_wr   (w_q_wr),
        .i_q_full (w_q_full),
        .o_rec    (w_rec_in)
    );

    // Decouple the compare from the counting and result hand-off
    wbps_queue #(
        .WIDTH (REC_W),
        .DEPTH (QUEUE_DEPTH_DEF)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_q_wr),
        .i_data  (w_rec_in),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .i_pop   (w_pop),
        .o_data  (w_rec_out)
    );

    // Back end: count hits, remember the first start, emit on the final byte
    wbps_back #(
        .OFFSET_BITS (OFFSET_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_rec     (w_rec_out),
        .o_pop     (w_pop),
        .o_out     (o_out)
    );

    // A result only appears when a queued record was there to produce it
    a_result_from_queue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> $past(w_q_valid))
        else $error("result raised with empty queue");

    // The unique flag and a nonzero count of one go together
    a_unique_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.unique_match |-> o_out.match_count == COUNT_OUT_W'(1))
        else $error("unique match without count of one");

    // Offset stays zero unless the match was unique
    a_offset_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.unique_match |-> o_out.match_offset == '0)
        else $error("offset set without unique match");

    // No result right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out.valid)
        else $error("result valid after reset");

endmodule
`default_nettype wire

/* bench/testbench.sv */
`timescale 1ns / 100ps
module testbench;
    import wbps_pkg::*;

    localparam int TIMEOUT_NS      = 20_000_000;
    localparam int DRAIN_CYCLES    = 6;
    localparam int RANDOM_ITEMS    = 1450;
    localparam int LONG_REGION_LEN = 256;     // one region where every byte is a hit

    // Indexes that map to no register; writes to them must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LOW  = 8'h04;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HIGH = 8'hFF;

    typedef struct packed {
        logic [COUNT_OUT_W-1:0]  count;
        logic [OFFSET_OUT_W-1:0] offset;
        logic                    uniq;
    } t_scan_report;

    logic i_clk;
    logic i_rst_n;

    wbps_cfg_if cfg_bus ();
    wbps_in_if  byte_bus ();
    wbps_out_if report_bus ();

    wildcard_byte_pattern_scanner_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_bus),
        .i_in    (byte_bus),
        .o_out   (report_bus)
    );

    // Scanner model: configuration copy and per-region state
    logic [63:0]          pat_low;
    logic [63:0]          pat_high;
    logic [CARE_W-1:0]    care_bits;
    logic [LEN_W-1:0]     pat_len;
    logic [BYTE_W-1:0]    recent [PATTERN_MAX_DEF];   // entry 0 is the newest byte
    logic [31:0]          seen_count;
    logic [15:0]          hit_count;
    logic [31:0]          first_hit;

    t_scan_report         expected_reports [$];
    logic [BYTE_W-1:0]    region_buf [$];

    // Traffic shaping
    bit throttle_in;
    bit throttle_out;
    int out_stall_left;

    // Bookkeeping
    int mismatches;
    int bytes_accepted;
    int regions_sent;
    int reports_checked;
    int unique_reports;
    int cfg_writes;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Mostly no gap, sometimes a short one, rarely a long one
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 75)
            return 0;
        if (roll < 97)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] pick_pattern_byte(logic [63:0] low, logic [63:0] high,
                                                     int idx);
        if (idx < 8)
            return low[8*idx +: 8];
        return high[8*(idx-8) +: 8];
    endfunction

    function automatic void clear_region_model();
        for (int k = 0; k < PATTERN_MAX_DEF; k++)
            recent[k] = '0;
        seen_count = '0;
        hit_count  = '0;
        first_hit  = '0;
    endfunction

    // Pattern byte 0 lines up with the oldest byte of the window slice
    function automatic bit pattern_ends_here(int len);
        for (int i = 0; i < len; i++) begin
            if (care_bits[i] && recent[len-1-i] != pick_pattern_byte(pat_low, pat_high, i))
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // Advance the model by one accepted byte; queue a report on the last byte
    function automatic void scan_byte(logic [7:0] b, logic last);
        t_scan_report rep;
        for (int k = PATTERN_MAX_DEF - 1; k > 0; k--)
            recent[k] = recent[k-1];
        recent[0] = b;
        if (seen_count != '1)
            seen_count = seen_count + 32'd1;
        if (pat_len != 0 && pat_len <= PATTERN_MAX_DEF && seen_count >= pat_len &&
            pattern_ends_here(pat_len)) begin
            if (hit_count == 0)
                first_hit = seen_count - pat_len;
            if (hit_count != '1)
                hit_count = hit_count + 16'd1;
        end
        if (last) begin
            rep.count  = hit_count;
            rep.uniq   = (hit_count == 1);
            rep.offset = rep.uniq ? first_hit : '0;
            expected_reports = {expected_reports, rep};
            clear_region_model();
        end
    endfunction

    function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] value);
        case (idx)
            REG_PATTERN_LOW:  pat_low   = value;
            REG_PATTERN_HIGH: pat_high  = value;
            REG_CARE_MASK:    care_bits = value[CARE_W-1:0];
            REG_PATTERN_LEN:  pat_len   = value[LEN_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic void report_mismatch(string what, logic [31:0] want, logic [31:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("[%0t] result %0d: %s expected 0x%0h got 0x%0h",
                     $realtime, reports_checked, what, want, got);
    endfunction

    // Track every accepted config write and byte
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cfg_bus.valid && cfg_bus.ready) begin
                apply_reg(cfg_bus.index, cfg_bus.data);
                cfg_writes++;
            end
            if (byte_bus.valid && byte_bus.ready) begin
                scan_byte(byte_bus.region_byte, byte_bus.last_byte);
                bytes_accepted++;
            end
        end
    end

    // Compare each result item against the oldest pending report
    always @(posedge i_clk) begin
        t_scan_report want;
        if (i_rst_n && report_bus.valid && report_bus.ready) begin
            reports_checked++;
            if (expected_reports.size() == 0) begin
                report_mismatch("unexpected result, count", '0,
                                32'(report_bus.match_count));
            end else begin
                want = expected_reports.pop_front();
                if (report_bus.match_count !== want.count)
                    report_mismatch("match_count", 32'(want.count),
                                    32'(report_bus.match_count));
                if (report_bus.match_offset !== want.offset)
                    report_mismatch("match_offset", want.offset, report_bus.match_offset);
                if (report_bus.unique_match !== want.uniq)
                    report_mismatch("unique_match", 32'(want.uniq),
                                    32'(report_bus.unique_match));
                if (want.uniq)
                    unique_reports++;
            end
        end
    end

    // Result-side back-pressure: random stalls unless throttling is off
    always @(negedge i_clk) begin
        int g;
        if (out_stall_left > 0) begin
            report_bus.ready <= 1'b0;
            out_stall_left--;
        end else begin
            g = throttle_out ? pick_gap() : 0;
            if (g > 0) begin
                report_bus.ready <= 1'b0;
                out_stall_left = g - 1;
            end else begin
                report_bus.ready <= 1'b1;
            end
        end
    end

    // Drive one byte; hold valid high into the next call unless a gap is drawn
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = throttle_in ? pick_gap() : 0;
        if (gap > 0) begin
            byte_bus.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        byte_bus.valid       <= 1'b1;
        byte_bus.region_byte <= b;
        byte_bus.last_byte   <= last;
        @(posedge i_clk);
        while (!byte_bus.ready)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_region();
        for (int i = 0; i < region_buf.size(); i++)
            send_byte(region_buf[i], i == region_buf.size() - 1);
        regions_sent++;
    endtask

    // Drop valid and wait for every pending result plus the pipeline tail
    task automatic wait_idle();
        byte_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_reports.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Leaves valid high; the caller lowers it after its last write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        @(posedge i_clk);
        while (!cfg_bus.ready)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic set_pattern(input logic [63:0] low, input logic [63:0] high,
                               input logic [63:0] care, input logic [63:0] len);
        wait_idle();
        write_reg(REG_PATTERN_LOW, low);
        write_reg(REG_PATTERN_HIGH, high);
        write_reg(REG_CARE_MASK, care);
        write_reg(REG_PATTERN_LEN, len);
        cfg_bus.valid <= 1'b0;
    endtask

    // Reset values give an empty pattern: nothing may match
    task automatic test_empty_pattern();
        throttle_in  = 1'b0;
        throttle_out = 1'b0;
        region_buf = '{8'h00, 8'hFF, 8'h55};
        send_region();
        // single-byte region, last flag on its first byte
        region_buf = '{8'hAA};
        send_region();
    endtask

    // Full-length pattern with every byte cared for, after one leading byte
    task automatic test_exact_match();
        logic [63:0] low;
        logic [63:0] high;
        low  = 64'h00FF_7F80_01FE_AA55;
        high = 64'hFFFF_0000_C33C_1248;
        set_pattern(low, high, 64'hFFFF, 64'(PATTERN_MAX_DEF));
        region_buf = '{8'h00};
        for (int i = 0; i < PATTERN_MAX_DEF; i++)
            region_buf = {region_buf, pick_pattern_byte(low, high, i)};
        send_region();
    endtask

    // Overlapping hits, wildcards and a region shorter than the pattern
    task automatic test_overlap_wildcard();
        throttle_in  = 1'b1;
        throttle_out = 1'b1;
        set_pattern(64'h4141, 64'h0, 64'h0003, 64'd2);
        region_buf = '{8'h41, 8'h41, 8'h41, 8'h41, 8'h42};
        send_region();
        // 'A' then two wildcards: starts 0 and 2 match
        set_pattern(64'h0041, 64'h0, 64'h0001, 64'd3);
        region_buf = '{8'h41, 8'h10, 8'h41, 8'hEF, 8'h20};
        send_region();
        region_buf = '{8'h41, 8'h41};
        send_region();
        // one all-wildcard byte against a one-byte region
        set_pattern(64'h0, 64'h0, 64'h0, 64'd1);
        region_buf = '{8'h7E};
        send_region();
    endtask

    // Lengths above the window never match; unmapped indexes and upper data bits are dropped
    task automatic test_overlong_and_masking();
        set_pattern(64'h0, 64'h0, 64'h0, 64'(PATTERN_MAX_DEF + 1));
        region_buf = '{8'h01, 8'h02, 8'h03, 8'h04, 8'h05};
        send_region();
        set_pattern('1, '1, 64'h0, 64'h1F);
        @(negedge i_clk);
        write_reg(REG_UNMAPPED_LOW, 64'h1);
        write_reg(REG_UNMAPPED_HIGH, 64'h2);
        cfg_bus.valid <= 1'b0;
        region_buf = '{8'hFF, 8'hFF, 8'h00};
        send_region();
        // length reads 2 after masking, care reads all-wildcard
        set_pattern(64'h0, 64'h0, 64'hFFFF_FFFF_FFFF_0000, 64'hFFFF_FFFF_FFFF_FFE2);
        region_buf = '{8'h11, 8'h22, 8'h33};
        send_region();
    endtask

    // One long region where every byte matches, sent with no gaps
    task automatic test_long_region();
        set_pattern(64'h0, 64'h0, 64'h0, 64'd1);
        throttle_in  = 1'b0;
        throttle_out = 1'b0;
        for (int i = 0; i < LONG_REGION_LEN; i++)
            send_byte(8'($urandom_range(0, 255)), i == LONG_REGION_LEN - 1);
        regions_sent++;
    endtask

    // Random configurations; most regions carry planted copies of the pattern
    task automatic test_random_regions();
        logic [63:0] low;
        logic [63:0] high;
        logic [63:0] care;
        int len;
        int roll;
        int rlen;
        int at;
        int start_items;
        bit dense;
        start_items = bytes_accepted;
        while (bytes_accepted - start_items < RANDOM_ITEMS) begin
            roll = $urandom_range(0, 19);
            if (roll == 0)
                len = 0;
            else if (roll == 1)
                len = $urandom_range(PATTERN_MAX_DEF + 1, 31);
            else if (roll < 7)
                len = $urandom_range(9, PATTERN_MAX_DEF);
            else
                len = $urandom_range(1, 8);
            low  = {$urandom, $urandom};
            high = {$urandom, $urandom};
            roll = $urandom_range(0, 9);
            if (roll == 0)
                care = 64'hFFFF;
            else if (roll == 1)
                care = 64'h0;
            else
                care = 64'($urandom_range(0, 65535));
            set_pattern(low, high, care, 64'(len));
            repeat ($urandom_range(4, 12)) begin
                throttle_in  = ($urandom_range(0, 3) != 0);
                throttle_out = ($urandom_range(0, 3) != 0);
                roll = $urandom_range(0, 9);
                if (roll == 0)
                    rlen = $urandom_range(1, 4);
                else if (roll == 1)
                    rlen = $urandom_range(40, 80);
                else
                    rlen = $urandom_range(8, 32);
                // dense regions reuse pattern bytes so near-misses are common
                dense = ($urandom_range(0, 2) == 0);
                region_buf.delete();
                for (int i = 0; i < rlen; i++)
                    region_buf = {region_buf,
                                  dense ? pick_pattern_byte(low, high, $urandom_range(0, 15))
                                        : 8'($urandom_range(0, 255))};
                // plant copies; any that starts near the end is cut short on purpose
                if ($urandom_range(0, 9) < 7) begin
                    repeat ($urandom_range(1, 3)) begin
                        at = $urandom_range(0, rlen - 1);
                        for (int i = 0; i < len && i < PAT_BYTES && at + i < rlen; i++)
                            if (care[i])
                                region_buf[at+i] = pick_pattern_byte(low, high, i);
                    end
                end
                send_region();
            end
        end
    endtask

    initial begin
        i_rst_n              = 1'b0;
        cfg_bus.valid        = 1'b0;
        cfg_bus.index        = REG_PATTERN_LOW;
        cfg_bus.data         = '0;
        byte_bus.valid       = 1'b0;
        byte_bus.region_byte = '0;
        byte_bus.last_byte   = 1'b0;
        report_bus.ready     = 1'b0;
        throttle_in          = 1'b0;
        throttle_out         = 1'b0;
        out_stall_left       = 0;
        pat_low              = '0;
        pat_high             = '0;
        care_bits            = '0;
        pat_len              = '0;
        clear_region_model();

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_empty_pattern();
        test_exact_match();
        test_overlap_wildcard();
        test_overlong_and_masking();
        test_long_region();
        test_random_regions();

        // let the tail of results drain before judging
        throttle_out = 1'b0;
        wait_idle();

        $display("scanned %0d bytes in %0d regions with %0d config writes",
                 bytes_accepted, regions_sent, cfg_writes);
        $display("checked %0d results, %0d with a single match; %0d mismatches, %0d pending",
                 reports_checked, unique_reports, mismatches, expected_reports.size());
        if (mismatches == 0 && expected_reports.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Hard stop in case a handshake never completes
    initial begin
        #(TIMEOUT_NS);
        $display("run limit reached with %0d results pending", expected_reports.size());
        $display("FAILURE");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/wbps_pkg.sv
hw/rtl/wbps_ifs.sv
hw/rtl/wbps_front.sv
hw/rtl/wbps_queue.sv
hw/rtl/wbps_back.sv
hw/rtl/wildcard_byte_pattern_scanner_core.sv
bench/testbench.sv
